FILE: hdl/cab_pkg.sv
// Package for the countdown alarm: widths, register map, reset values and
// the config/control structs shared by the register file, beeper and fader.
// No dependencies.
`timescale 1ns / 1ps

package cab_pkg;

  // Timestamp width; all time differences wrap modulo 2^TIME_BITS.
  localparam int TIME_BITS = 32;
  localparam int TGT_W     = 24;
  localparam int CMP_W     = (TIME_BITS > TGT_W) ? TIME_BITS : TGT_W;

  // APB register map
  localparam int ADDR_W = 5;
  localparam int IDX_W  = ADDR_W - 2;

  localparam logic [IDX_W-1:0] REG_UNIT_MS       = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_BEEP_ON_MS    = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_BEEP_OFF_MS   = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_BEEP_TOTAL    = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_FADE_INTERVAL = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_FADE_STEP     = IDX_W'(5);
  localparam logic [IDX_W-1:0] REG_FADE_PEAK     = IDX_W'(6);

  localparam logic [15:0] UNIT_MS_RST       = 16'd60000;
  localparam logic [9:0]  BEEP_ON_MS_RST    = 10'd100;
  localparam logic [9:0]  BEEP_OFF_MS_RST   = 10'd200;
  localparam logic [3:0]  BEEP_TOTAL_RST    = 4'd3;
  localparam logic [7:0]  FADE_INTERVAL_RST = 8'd10;
  localparam logic [7:0]  FADE_STEP_RST     = 8'd5;
  localparam logic [7:0]  FADE_PEAK_RST     = 8'd255;

  // Common-anode LED: full duty code means dark.
  localparam logic [7:0] DUTY_DARK = 8'hFF;
  localparam logic [7:0] DUTY_FULL = 8'h00;

  typedef logic [TIME_BITS-1:0] tstamp_t;

  typedef struct packed {
    logic [15:0] unit_ms;
    logic [9:0]  beep_on_ms;
    logic [9:0]  beep_off_ms;
    logic [3:0]  beep_total;
    logic [7:0]  fade_interval_ms;
    logic [7:0]  fade_step;
    logic [7:0]  fade_peak;
  } cab_cfg_t;

  // Per-item control from the countdown sequencer to beeper and fader.
  typedef struct packed {
    logic start;   // start command transfer
    logic detect;  // tick that detects completion
    logic run;     // tick while complete
  } cab_ctl_t;

endpackage

FILE: hdl/cab_regs.sv
// APB configuration register file for the countdown alarm.
// Depends on cab_pkg (register map, reset values, cab_cfg_t).
`timescale 1ns / 1ps

module cab_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [cab_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output cab_pkg::cab_cfg_t         cfg
);

  cab_pkg::cab_cfg_t          cfg_r;
  logic [cab_pkg::IDX_W-1:0]  idx;
  logic                       wr_en;

  assign idx   = paddr[cab_pkg::ADDR_W-1:2];
  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.unit_ms          <= cab_pkg::UNIT_MS_RST;
      cfg_r.beep_on_ms       <= cab_pkg::BEEP_ON_MS_RST;
      cfg_r.beep_off_ms      <= cab_pkg::BEEP_OFF_MS_RST;
      cfg_r.beep_total       <= cab_pkg::BEEP_TOTAL_RST;
      cfg_r.fade_interval_ms <= cab_pkg::FADE_INTERVAL_RST;
      cfg_r.fade_step        <= cab_pkg::FADE_STEP_RST;
      cfg_r.fade_peak        <= cab_pkg::FADE_PEAK_RST;
    end else if (wr_en) begin
      case (idx)
        cab_pkg::REG_UNIT_MS:       cfg_r.unit_ms          <= pwdata[15:0];
        cab_pkg::REG_BEEP_ON_MS:    cfg_r.beep_on_ms       <= pwdata[9:0];
        cab_pkg::REG_BEEP_OFF_MS:   cfg_r.beep_off_ms      <= pwdata[9:0];
        cab_pkg::REG_BEEP_TOTAL:    cfg_r.beep_total       <= pwdata[3:0];
        cab_pkg::REG_FADE_INTERVAL: cfg_r.fade_interval_ms <= pwdata[7:0];
        cab_pkg::REG_FADE_STEP:     cfg_r.fade_step        <= pwdata[7:0];
        cab_pkg::REG_FADE_PEAK:     cfg_r.fade_peak        <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      cab_pkg::REG_UNIT_MS:       prdata = {16'd0, cfg_r.unit_ms};
      cab_pkg::REG_BEEP_ON_MS:    prdata = {22'd0, cfg_r.beep_on_ms};
      cab_pkg::REG_BEEP_OFF_MS:   prdata = {22'd0, cfg_r.beep_off_ms};
      cab_pkg::REG_BEEP_TOTAL:    prdata = {28'd0, cfg_r.beep_total};
      cab_pkg::REG_FADE_INTERVAL: prdata = {24'd0, cfg_r.fade_interval_ms};
      cab_pkg::REG_FADE_STEP:     prdata = {24'd0, cfg_r.fade_step};
      cab_pkg::REG_FADE_PEAK:     prdata = {24'd0, cfg_r.fade_peak};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

FILE: hdl/cab_beep.sv
// Beeper sequencer: toggles the tone beep_total*2 times with on/off waits.
// Depends on cab_pkg (cab_ctl_t, cab_cfg_t, tstamp_t).
`timescale 1ns / 1ps

module cab_beep (
  input  logic               clk,
  input  logic               rst_n,
  input  cab_pkg::cab_ctl_t  ctl,
  input  cab_pkg::tstamp_t   now_nxt,
  input  cab_pkg::cab_cfg_t  cfg,
  output logic               tone
);

  cab_pkg::tstamp_t stamp_r, stamp_nxt;
  cab_pkg::tstamp_t since;
  logic [4:0]       toggles_r, toggles_nxt;
  logic             wait_off_r, wait_off_nxt;
  logic             tone_r, tone_nxt;
  logic [9:0]       wait_ms;
  logic             fire;

  assign since   = now_nxt - stamp_r;
  assign wait_ms = wait_off_r ? cfg.beep_off_ms : cfg.beep_on_ms;
  assign fire    = ctl.run && (toggles_r < {cfg.beep_total, 1'b0})
                   && (since > cab_pkg::TIME_BITS'(wait_ms));

  always_comb begin
    stamp_nxt    = stamp_r;
    toggles_nxt  = toggles_r;
    wait_off_nxt = wait_off_r;
    tone_nxt     = tone_r;
    if (ctl.detect) begin
      // new completion: restart the beep count, keep tone and wait phase
      stamp_nxt   = now_nxt;
      toggles_nxt = 5'd0;
    end else if (fire) begin
      tone_nxt     = ~toggles_r[0];
      wait_off_nxt = ~toggles_r[0];
      stamp_nxt    = now_nxt;
      toggles_nxt  = toggles_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stamp_r    <= '0;
      toggles_r  <= 5'd0;
      wait_off_r <= 1'b0;
      tone_r     <= 1'b0;
    end else begin
      stamp_r    <= stamp_nxt;
      toggles_r  <= toggles_nxt;
      wait_off_r <= wait_off_nxt;
      tone_r     <= tone_nxt;
    end
  end

  assign tone = tone_r;

endmodule

FILE: hdl/cab_fade.sv
// Red triangle fader and LED duty registers (inverted for common anode).
// Depends on cab_pkg (cab_ctl_t, cab_cfg_t, tstamp_t, duty constants).
`timescale 1ns / 1ps

module cab_fade (
  input  logic               clk,
  input  logic               rst_n,
  input  cab_pkg::cab_ctl_t  ctl,
  input  cab_pkg::tstamp_t   now_nxt,
  input  cab_pkg::cab_cfg_t  cfg,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue
);

  cab_pkg::tstamp_t    stamp_r, stamp_nxt;
  cab_pkg::tstamp_t    since;
  logic signed [10:0]  level_r, level_nxt;
  logic signed [10:0]  step_s, peak_s, level_up, level_dn;
  logic                down_r, down_nxt;
  logic [7:0]          red_r, red_nxt, green_r, green_nxt, blue_r, blue_nxt;
  logic [7:0]          shown;
  logic                due;

  assign since    = now_nxt - stamp_r;
  assign due      = ctl.run && (since > cab_pkg::TIME_BITS'(cfg.fade_interval_ms));
  assign step_s   = signed'({3'b000, cfg.fade_step});
  assign peak_s   = signed'({3'b000, cfg.fade_peak});
  assign level_up = level_r + step_s;
  assign level_dn = level_r - step_s;

  // saturate the level to 0..255
  always_comb begin
    if (level_r[10])
      shown = 8'd0;
    else if (level_r[9:8] != 2'b00)
      shown = 8'd255;
    else
      shown = level_r[7:0];
  end

  always_comb begin
    stamp_nxt = stamp_r;
    level_nxt = level_r;
    down_nxt  = down_r;
    red_nxt   = red_r;
    green_nxt = green_r;
    blue_nxt  = blue_r;
    if (ctl.start) begin
      red_nxt   = cab_pkg::DUTY_DARK;
      green_nxt = cab_pkg::DUTY_FULL;
      blue_nxt  = cab_pkg::DUTY_DARK;
    end else if (due) begin
      stamp_nxt = now_nxt;
      red_nxt   = ~shown;
      green_nxt = cab_pkg::DUTY_DARK;
      blue_nxt  = cab_pkg::DUTY_DARK;
      if (!down_r) begin
        level_nxt = level_up;
        if (level_up >= peak_s)
          down_nxt = 1'b1;
      end else begin
        level_nxt = level_dn;
        if (level_dn <= 11'sd0)
          down_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stamp_r <= '0;
      level_r <= 11'sd0;
      down_r  <= 1'b0;
      red_r   <= cab_pkg::DUTY_DARK;
      green_r <= cab_pkg::DUTY_DARK;
      blue_r  <= cab_pkg::DUTY_DARK;
    end else begin
      stamp_r <= stamp_nxt;
      level_r <= level_nxt;
      down_r  <= down_nxt;
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign red   = red_r;
  assign green = green_r;
  assign blue  = blue_r;

endmodule

FILE: hdl/countdown_alarm_beeper_fader.sv
// Top level of the countdown alarm with beeper and red fader.
// Depends on cab_pkg, cab_regs, cab_beep and cab_fade.
`timescale 1ns / 1ps

// Usage
//   Input stream: one transfer per command. in_tuser is the command (0 = one
//   millisecond tick, 1 = start), in_tdata[7:0] the minute count of a start.
//   Output stream: exactly one result transfer per input transfer, carrying
//   mode, tone and the three inverted LED duties after that command.
//   APB port: seven registers at byte addresses 0, 4, ... 24; writes take
//   effect at the access edge, reads return the register value.
// Latency and throughput
//   Each command is applied to the state in the cycle it is accepted; its
//   result is valid the next cycle. One command per cycle is sustained while
//   out_tready stays high: the time compares, fade step and the 8x16 target
//   multiply are all one level of logic ahead of the state registers, which
//   double as the result register.
// Reset
//   Synchronous, active low: time, stamps and counters clear, mode is idle,
//   all LEDs dark, registers return to their defaults, no result pending.
// Backpressure
//   While a result waits and out_tready is low, in_tready drops and the
//   result holds. A new command is taken in the same cycle the pending
//   result is taken.
module countdown_alarm_beeper_fader (
  input  logic                       clk,
  input  logic                       rst_n,
  // input stream
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] minutes
  input  logic                       in_tuser,   // [0] cmd
  // result stream
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [31:0]                out_tdata,  // [1:0] mode, [2] tone_on,
                                                 // [10:3] red_pwm,
                                                 // [18:11] green_pwm,
                                                 // [26:19] blue_pwm, rest 0
  // configuration
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [cab_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_COUNT = 2'd1,
    MODE_DONE  = 2'd2
  } mode_t;

  cab_pkg::cab_cfg_t       cfg;
  cab_pkg::cab_ctl_t       ctl;
  cab_pkg::tstamp_t        now_r, now_nxt;
  cab_pkg::tstamp_t        start_stamp_r, start_stamp_nxt;
  cab_pkg::tstamp_t        elapsed;
  logic [cab_pkg::TGT_W-1:0] target_r, target_nxt, product;
  mode_t                   mode_r, mode_nxt;
  logic                    out_tvalid_r, out_tvalid_nxt;
  logic                    accept, tick;
  logic                    tone;
  logic [7:0]              red, green, blue;

  assign cfg_pready = 1'b1;

  // Hold input off while a result is stuck downstream.
  assign in_tready = rst_n && (!out_tvalid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign tick      = accept && !in_tuser;

  // Time advances only on a tick; the update then runs at the new time.
  assign now_nxt = tick ? (now_r + cab_pkg::TIME_BITS'(1)) : now_r;
  assign elapsed = now_nxt - start_stamp_r;
  assign product = cab_pkg::TGT_W'(in_tdata) * cab_pkg::TGT_W'(cfg.unit_ms);

  assign ctl.start  = accept && in_tuser;
  assign ctl.detect = tick && (mode_r == MODE_COUNT)
                      && (cab_pkg::CMP_W'(elapsed) > cab_pkg::CMP_W'(target_r));
  assign ctl.run    = tick && (mode_r == MODE_DONE);

  always_comb begin
    mode_nxt        = mode_r;
    target_nxt      = target_r;
    start_stamp_nxt = start_stamp_r;
    if (ctl.start) begin
      // restart from the current time; beeper and fade keep their place
      mode_nxt        = MODE_COUNT;
      target_nxt      = product;
      start_stamp_nxt = now_r;
    end else if (ctl.detect) begin
      mode_nxt = MODE_DONE;
    end
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (accept)
      out_tvalid_nxt = 1'b1;
    else if (out_tready)
      out_tvalid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r         <= '0;
      start_stamp_r <= '0;
      target_r      <= '0;
      mode_r        <= MODE_IDLE;
      out_tvalid_r  <= 1'b0;
    end else begin
      now_r         <= now_nxt;
      start_stamp_r <= start_stamp_nxt;
      target_r      <= target_nxt;
      mode_r        <= mode_nxt;
      out_tvalid_r  <= out_tvalid_nxt;
    end
  end

  cab_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  cab_beep u_beep (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .now_nxt (now_nxt),
    .cfg     (cfg),
    .tone    (tone)
  );

  cab_fade u_fade (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .now_nxt (now_nxt),
    .cfg     (cfg),
    .red     (red),
    .green   (green),
    .blue    (blue)
  );

  // The state registers are the result register: a new command only lands
  // when the previous result is gone or leaving this cycle.
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'd0, blue, green, red, tone, mode_r};

  // A start transfer moves to counting and leaves the time untouched.
  a_start_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser) |=> (mode_r == MODE_COUNT) && $stable(now_r))
    else $error("start did not enter counting or moved the time");

  // A tick transfer advances the time by exactly one.
  a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
    tick |=> (now_r == $past(now_r) + cab_pkg::TIME_BITS'(1)))
    else $error("tick did not advance the time by one");

  // Every accepted command leaves a result pending.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_tvalid)
    else $error("accepted command produced no result");

  // The tone can only switch on while the alarm is complete.
  a_tone_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(tone) |-> (mode_r == MODE_DONE))
    else $error("tone switched on outside complete mode");

endmodule

FILE: dv/tb.sv
// Self-checking testbench for countdown_alarm_beeper_fader: ticks and start commands
// stream in, and every result transfer is checked against a cycle-free alarm predictor.
// Depends on cab_pkg and the countdown_alarm_beeper_fader RTL.
`timescale 1ns / 1ps

module tb;
  import cab_pkg::*;

  // Commands carried on in_tuser and modes reported in out_tdata[1:0]
  typedef enum logic {CMD_TICK = 1'b0, CMD_START = 1'b1} alarm_cmd_e;
  typedef enum logic [1:0] {MODE_IDLE = 2'd0, MODE_COUNT = 2'd1, MODE_DONE = 2'd2} alarm_mode_e;
  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_e;

  typedef struct packed {
    alarm_cmd_e  cmd;
    logic [7:0]  minutes;
  } alarm_item_t;

  // Same bit order as out_tdata: mode in the lowest bits, blue at the top
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       tone;
    logic [1:0] mode;
  } alarm_out_t;

  localparam int PHASE_ITEMS  = 215;
  localparam int RAND_PHASES  = 8;
  localparam int STALL_LIMIT  = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  alarm_item_t pending_q[$];
  alarm_out_t  expected_q[$];
  alarm_item_t on_bus;
  idle_e       idle_mode = IDLE_NONE;
  int          n_errors = 0;
  int          quiet_cycles = 0;

  // Predictor state: configuration shadow and alarm state
  cab_cfg_t    alarm_cfg;
  logic [31:0] t_now, count_from, beep_mark, fade_mark;
  logic [23:0] target_len;
  alarm_mode_e alarm_mode;
  logic [4:0]  beep_count;
  logic        await_off, tone_now, descending;
  int          fade_pos;
  logic [7:0]  duty_r, duty_g, duty_b;

  countdown_alarm_beeper_fader dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] minutes
    .in_tuser   (in_tuser),    // [0] cmd
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [1:0] mode, [2] tone_on, [10:3] red, [18:11] green,
                               // [26:19] blue, [31:27] zero
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Alarm predictor: apply one command, return the outputs it leaves behind.
  // A tick advances the time first and then updates at the new time; a start
  // never advances the time.
  // ---------------------------------------------------------------------------
  function automatic alarm_out_t step_alarm(input alarm_item_t it);
    logic [31:0] beep_wait;
    logic [31:0] elapsed;
    int          shown;
    alarm_out_t  r;
    if (it.cmd == CMD_START) begin
      // Restart from the current time; tone, beep phase and fade stay put
      target_len = 24'(32'(it.minutes) * 32'(alarm_cfg.unit_ms));
      count_from = t_now;
      alarm_mode = MODE_COUNT;
      duty_r = DUTY_DARK;
      duty_g = DUTY_FULL;
      duty_b = DUTY_DARK;
    end else begin
      t_now = t_now + 32'd1;
      if (alarm_mode == MODE_COUNT) begin
        elapsed = t_now - count_from;
        // The tick that detects completion neither beeps nor fades
        if (elapsed > 32'(target_len)) begin
          alarm_mode = MODE_DONE;
          beep_mark  = t_now;
          beep_count = '0;
        end
      end else if (alarm_mode == MODE_DONE) begin
        if (int'(beep_count) < 2 * int'(alarm_cfg.beep_total)) begin
          beep_wait = await_off ? 32'(alarm_cfg.beep_off_ms) : 32'(alarm_cfg.beep_on_ms);
          elapsed = t_now - beep_mark;
          if (elapsed > beep_wait) begin
            // Even toggle count switches the tone on, odd switches it off
            tone_now   = ~beep_count[0];
            await_off  = ~beep_count[0];
            beep_mark  = t_now;
            beep_count = beep_count + 5'd1;
          end
        end
        elapsed = t_now - fade_mark;
        if (elapsed > 32'(alarm_cfg.fade_interval_ms)) begin
          fade_mark = t_now;
          // Show the level from before this step, saturated to a byte
          shown  = fade_pos < 0 ? 0 : (fade_pos > 255 ? 255 : fade_pos);
          duty_r = 8'(255 - shown);
          duty_g = DUTY_DARK;
          duty_b = DUTY_DARK;
          if (!descending) begin
            fade_pos += int'(alarm_cfg.fade_step);
            if (fade_pos >= int'(alarm_cfg.fade_peak)) descending = 1'b1;
          end else begin
            fade_pos -= int'(alarm_cfg.fade_step);
            if (fade_pos <= 0) descending = 1'b0;
          end
        end
      end
    end
    r.mode  = alarm_mode;
    r.tone  = tone_now;
    r.red   = duty_r;
    r.green = duty_g;
    r.blue  = duty_b;
    return r;
  endfunction

  function automatic bit hold_sender();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 67;
      IDLE_BOTH:   return $urandom_range(0, 99) < 22;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit hold_receiver();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(0, 99) < 67;
      IDLE_BOTH:     return $urandom_range(0, 99) < 22;
      default:       return 1'b0;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      n_errors++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present queued commands; predict each one at its transfer edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive
    logic go;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) expected_q.push_back(step_alarm(on_bus));
      // Hold a command that was not taken; otherwise pick the next or idle
      if (!(in_tvalid && !in_tready)) begin
        go = pending_q.size() != 0 && !hold_sender();
        if (go) begin
          on_bus = pending_q.pop_front();
          in_tuser <= on_bus.cmd;
          in_tdata <= on_bus.minutes;
        end
        in_tvalid <= go;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result transfer with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : observe
    alarm_out_t seen;
    alarm_out_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen = alarm_out_t'(out_tdata[26:0]);
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, out_tdata);
          n_errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("mode", 8'(want.mode), 8'(seen.mode));
          check_field("tone_on", 8'(want.tone), 8'(seen.tone));
          check_field("red_pwm", want.red, seen.red);
          check_field("green_pwm", want.green, seen.green);
          check_field("blue_pwm", want.blue, seen.blue);
        end
        check_field("padding", 8'd0, 8'(out_tdata[31:27]));
      end
      out_tready <= !hold_receiver();
    end
  end

  // Watchdog: give up after a long stretch without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("countdown_alarm_beeper_fader test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_tick(input int n);
    alarm_item_t it;
    repeat (n) begin
      it.cmd     = CMD_TICK;
      it.minutes = 8'($urandom);  // ignored by a tick, so let the bits wander
      pending_q.push_back(it);
    end
  endtask

  task automatic queue_start(input logic [7:0] m);
    alarm_item_t it;
    it.cmd     = CMD_START;
    it.minutes = m;
    pending_q.push_back(it);
  endtask

  // Write one register; junk above the field width checks the masking
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] value,
                           input int width);
    logic [31:0] wdata;
    wdata = value;
    if ($urandom_range(0, 1) == 1) wdata = wdata | ($urandom << width);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    // Transfer completes at the first access edge with pready high
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_UNIT_MS:       alarm_cfg.unit_ms          = wdata[15:0];
      REG_BEEP_ON_MS:    alarm_cfg.beep_on_ms       = wdata[9:0];
      REG_BEEP_OFF_MS:   alarm_cfg.beep_off_ms      = wdata[9:0];
      REG_BEEP_TOTAL:    alarm_cfg.beep_total       = wdata[3:0];
      REG_FADE_INTERVAL: alarm_cfg.fade_interval_ms = wdata[7:0];
      REG_FADE_STEP:     alarm_cfg.fade_step        = wdata[7:0];
      REG_FADE_PEAK:     alarm_cfg.fade_peak        = wdata[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input cab_cfg_t c);
    write_reg(REG_UNIT_MS, 32'(c.unit_ms), 16);
    write_reg(REG_BEEP_ON_MS, 32'(c.beep_on_ms), 10);
    write_reg(REG_BEEP_OFF_MS, 32'(c.beep_off_ms), 10);
    write_reg(REG_BEEP_TOTAL, 32'(c.beep_total), 4);
    write_reg(REG_FADE_INTERVAL, 32'(c.fade_interval_ms), 8);
    write_reg(REG_FADE_STEP, 32'(c.fade_step), 8);
    write_reg(REG_FADE_PEAK, 32'(c.fade_peak), 8);
  endtask

  // Settings per random phase: defaults, both extremes, a fixed fast set, then short random ones
  function automatic cab_cfg_t pick_cfg(input int p);
    cab_cfg_t c;
    case (p)
      0: c = '{UNIT_MS_RST, BEEP_ON_MS_RST, BEEP_OFF_MS_RST, BEEP_TOTAL_RST,
               FADE_INTERVAL_RST, FADE_STEP_RST, FADE_PEAK_RST};
      1: c = '{16'hFFFF, 10'h3FF, 10'h3FF, 4'hF, 8'hFF, 8'hFF, 8'hFF};
      2: c = '{16'd0, 10'd0, 10'd0, 4'd0, 8'd0, 8'd0, 8'd0};
      3: c = '{16'd1, 10'd0, 10'd0, 4'hF, 8'd0, 8'd1, 8'd1};
      default: begin
        c.unit_ms          = 16'($urandom_range(1, 4));
        c.beep_on_ms       = 10'($urandom_range(0, 12));
        c.beep_off_ms      = 10'($urandom_range(0, 12));
        c.beep_total       = 4'($urandom_range(0, 15));
        c.fade_interval_ms = 8'($urandom_range(0, 6));
        c.fade_step        = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        c.fade_peak        = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      end
    endcase
    return c;
  endfunction

  // Mostly full countdowns (start, then enough ticks to complete, beep and
  // fade), mixed with bursts of random starts and ticks
  task automatic fill_phase(input int budget);
    int          left;
    int          most;
    int          ticks;
    logic [7:0]  m;
    logic [23:0] tgt;
    left = budget;
    while (left > 0) begin
      if ($urandom_range(0, 9) < 8) begin
        most = (alarm_cfg.unit_ms == 0) ? 255 : int'(300 / alarm_cfg.unit_ms);
        if (most > 255) most = 255;
        m     = 8'($urandom_range(0, most));
        tgt   = 24'(32'(m) * 32'(alarm_cfg.unit_ms));
        ticks = int'(tgt) + 1 + int'($urandom_range(0, 40 + 2 * (int'(alarm_cfg.beep_on_ms)
                                                        + int'(alarm_cfg.beep_off_ms))));
        queue_start(m);
        left--;
        if (ticks > left) ticks = left;
        queue_tick(ticks);
        left -= ticks;
      end else begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 1) == 1) queue_start(8'($urandom));
          else queue_tick(1);
          left--;
        end
      end
    end
  endtask

  // Wait until every queued command has been taken and every result checked
  task automatic drain();
    while (pending_q.size() != 0 || in_tvalid || expected_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed checks, then random phases
  // ---------------------------------------------------------------------------
  initial begin
    alarm_cfg = '{UNIT_MS_RST, BEEP_ON_MS_RST, BEEP_OFF_MS_RST, BEEP_TOTAL_RST,
                  FADE_INTERVAL_RST, FADE_STEP_RST, FADE_PEAK_RST};
    t_now = '0; count_from = '0; beep_mark = '0; fade_mark = '0;
    target_len = '0; alarm_mode = MODE_IDLE; beep_count = '0;
    await_off = 1'b0; tone_now = 1'b0; descending = 1'b0; fade_pos = 0;
    duty_r = DUTY_DARK; duty_g = DUTY_DARK; duty_b = DUTY_DARK;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: idle ticks, longest start, restart while counting,
    // back-to-back starts, zero-length countdown completing on one tick
    queue_tick(2);
    queue_start(8'd255);
    queue_tick(2);
    queue_start(8'd85);
    queue_start(8'd0);
    queue_tick(3);
    drain();

    // Fastest settings: a beep toggle and a full fade swing on every tick,
    // then a restart during completion that keeps tone and fade position
    apply_cfg('{16'd1, 10'd0, 10'd0, 4'hF, 8'd0, 8'hFF, 8'hFF});
    queue_start(8'd0);
    queue_tick(6);
    queue_start(8'd2);
    queue_tick(6);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      apply_cfg(pick_cfg(p));
      idle_mode = idle_e'(p % 4);
      fill_phase(PHASE_ITEMS);
      drain();
    end

    // One result per command, so any stray result reaches the monitor before the verdict
    repeat (5) @(posedge clk);
    if (n_errors == 0) begin
      $display("countdown_alarm_beeper_fader test passed");
    end else begin
      $display("countdown_alarm_beeper_fader test failed");
    end
    $finish;
  end

endmodule
